### rtl/core/mot_pkg.sv
// ----------------------------------------------------------------------------
// mot_pkg: shared types, constants and helpers of the online mlp trainer
// widths, command and step codes, lane control struct, sigmoid table
// ----------------------------------------------------------------------------
package mot_pkg;

   localparam int NUM_INPUTS  = 3;
   localparam int NUM_HIDDEN  = 2;
   // sigmoid segments are 2**SIG_LOG2 (range 5 to 12)
   localparam int SIG_LOG2    = 8;
   localparam int SIG_DEPTH   = 1 << SIG_LOG2;
   localparam int SIG_SHIFT   = 20 - SIG_LOG2;

   localparam int FEAT_W      = 16;
   localparam int WEIGHT_W    = 24;
   localparam int ACC_W       = 42;
   localparam int MUL_A_W     = 41;
   localparam int MUL_B_W     = 25;
   localparam int MUL_P_W     = 66;
   localparam int DOUT_W      = 18;
   localparam int WSUM_W      = 34;
   localparam int SEL_W       = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 56;

   typedef enum logic [1:0] {
      CMD_INFER = 2'd0,
      CMD_TRAIN = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      L_NOP,
      L_LOAD,
      L_MAC,
      L_NET,
      L_LOOK,
      L_INTERP,
      L_OMUL,
      L_DERIV,
      L_BACK,
      L_HDELTA,
      L_LRO,
      L_WOUPD,
      L_LRH,
      L_WHUPD
   } lane_op_type;

   typedef enum logic [2:0] {
      M_NOP,
      M_NET,
      M_LOOK,
      M_INTERP,
      M_DERIV,
      M_DOUT
   } merge_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_HMAC,
      ST_HNET,
      ST_HLOOK,
      ST_HINTERP,
      ST_OMUL,
      ST_ONET,
      ST_OLOOK,
      ST_OINTERP,
      ST_ODERIV,
      ST_ODOUT,
      ST_BACK,
      ST_HDELTA,
      ST_LRO,
      ST_WOUPD,
      ST_LRH,
      ST_WHUPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      lane_op_type      op;
      logic [SEL_W-1:0] sel;
      logic             wr_hidden;
      logic             wr_out;
   } lane_ctrl_type;

   typedef struct packed {
      logic [15:0]        t0;
      logic signed [16:0] diff;
      logic [19:0]        frac;
   } sig_seg_type;

   typedef logic signed [FEAT_W-1:0] feat_array_type [NUM_INPUTS];
   typedef logic signed [ACC_W-1:0]  term_array_type [NUM_HIDDEN];
   typedef logic [15:0]              sig_table_type  [0:SIG_DEPTH];

   // shift-subtract divide, evaluated at elaboration only
   function automatic longint unsigned udiv64(input longint unsigned n,
                                              input longint unsigned d);
      longint unsigned rem;
      longint unsigned q;
      rem = 0;
      q   = 0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], n[i]};
         if (rem >= d) begin
            rem  = rem - d;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [15:0] sig_entry(input int k);
      longint x, t, a, a2, a3, a4, a5, r, den, num;
      longint unsigned s;
      x  = (longint'(k) <<< SIG_SHIFT) - (longint'(1) <<< 19);
      t  = (x < 0) ? -x : x;
      a  = t <<< 6;
      a2 = (a * a) >>> 30;
      a3 = (a2 * a) >>> 30;
      a4 = (a3 * a) >>> 30;
      a5 = (a4 * a) >>> 30;
      r  = (longint'(1) <<< 30) + a2 / 2 + a4 / 24 - a - a3 / 6 - a5 / 120;
      for (int n = 0; n < 8; n++) begin
         r = (r * r + (longint'(1) <<< 29)) >>> 30;
      end
      den = (longint'(1) <<< 30) + r;
      if (x >= 0) begin
         num = (longint'(1) <<< 46) + den / 2;
      end else begin
         num = (r <<< 16) + den / 2;
      end
      s = udiv64(longint'(num), longint'(den));
      return (s > 65535) ? 16'hffff : s[15:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      for (int k = 0; k <= SIG_DEPTH; k++) begin
         tbl[k] = sig_entry(k);
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

   // round half up by 2**k (floor of v/2**k + 1/2)
   function automatic logic signed [MUL_P_W-1:0] rnd_shift(
      input logic signed [MUL_P_W-1:0] v, input int k);
      logic signed [MUL_P_W-1:0] half;
      half = '0;
      half[k-1] = 1'b1;
      return (v + half) >>> k;
   endfunction

   // clamp net to [-8, 8] and offset to 0..2**20
   function automatic logic [20:0] sig_arg(input logic signed [ACC_W-1:0] z);
      logic signed [ACC_W-1:0] off;
      off = z + 42'sd524288;
      if (z > 42'sd524288) begin
         return 21'h100000;
      end else if (z < -42'sd524288) begin
         return 21'h000000;
      end
      return off[20:0];
   endfunction

   function automatic sig_seg_type sig_fetch(input logic [20:0] u);
      logic [SIG_LOG2:0] k;
      logic [15:0]       t1;
      sig_seg_type       s;
      k      = u[20:SIG_SHIFT];
      s.frac = {u[SIG_SHIFT-1:0], {SIG_LOG2{1'b0}}};
      s.t0   = SIG_TABLE[k];
      t1     = (k == (SIG_LOG2+1)'(SIG_DEPTH)) ? s.t0 : SIG_TABLE[k + 1'b1];
      s.diff = signed'({1'b0, t1}) - signed'({1'b0, s.t0});
      return s;
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] wsat(
      input logic signed [WSUM_W-1:0] v);
      if (v > 34'sd8388607) begin
         return 24'sh7fffff;
      end else if (v < -34'sd8388608) begin
         return 24'sh800000;
      end
      return v[WEIGHT_W-1:0];
   endfunction

   function automatic logic wclip(input logic signed [WSUM_W-1:0] v);
      return (v > 34'sd8388607) || (v < -34'sd8388608);
   endfunction

endpackage

### rtl/core/mot_lane.sv
// ----------------------------------------------------------------------------
// mot_lane: one hidden neuron lane
// holds the neuron's weights, one shared multiplier for forward, back and update
// ----------------------------------------------------------------------------
module mot_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mot_pkg::lane_ctrl_type                ctrl,
   input  mot_pkg::feat_array_type               features,
   input  logic [15:0]                           learn_rate,
   input  logic signed [mot_pkg::DOUT_W-1:0]     d_out,
   input  logic signed [mot_pkg::WEIGHT_W-1:0]   wr_value,
   output logic [15:0]                           hidden,
   output logic signed [mot_pkg::ACC_W-1:0]      out_term,
   output logic                                  sat
);
   import mot_pkg::*;

   logic signed [WEIGHT_W-1:0] wh_ff [NUM_INPUTS];
   logic signed [WEIGHT_W-1:0] wo_ff;
   logic                       sat_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [20:0]                u_ff;
   logic [15:0]                t0_ff;
   logic signed [16:0]         diff_ff;
   logic [19:0]                frac_ff;
   logic [15:0]                h_ff;
   logic [14:0]                dh_ff;
   logic signed [25:0]         g_ff;
   logic signed [23:0]         dhid_ff;
   logic signed [MUL_A_W-1:0]  lrd_ff;
   logic signed [ACC_W-1:0]    term_ff;

   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0]  mul_p;
   logic signed [MUL_P_W-1:0]  r16, r20, r28, r32, net_r;
   logic signed [WSUM_W-1:0]   wo_sum, wh_sum;
   sig_seg_type                seg;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         L_MAC: begin
            mul_a = MUL_A_W'(features[ctrl.sel]);
            mul_b = MUL_B_W'(wh_ff[ctrl.sel]);
         end
         L_INTERP: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = {5'b0, frac_ff};
         end
         L_OMUL: begin
            mul_a = {25'b0, h_ff};
            mul_b = MUL_B_W'(wo_ff);
         end
         L_DERIV: begin
            mul_a = {25'b0, h_ff};
            mul_b = {8'b0, 17'h10000 - {1'b0, h_ff}};
         end
         L_BACK: begin
            mul_a = MUL_A_W'(d_out);
            mul_b = MUL_B_W'(wo_ff);
         end
         L_HDELTA: begin
            mul_a = MUL_A_W'(g_ff);
            mul_b = {10'b0, dh_ff};
         end
         L_LRO: begin
            mul_a = MUL_A_W'(d_out);
            mul_b = {9'b0, learn_rate};
         end
         L_WOUPD: begin
            mul_a = lrd_ff;
            mul_b = {9'b0, h_ff};
         end
         L_LRH: begin
            mul_a = MUL_A_W'(dhid_ff);
            mul_b = {9'b0, learn_rate};
         end
         L_WHUPD: begin
            mul_a = lrd_ff;
            mul_b = MUL_B_W'(features[ctrl.sel]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   assign r16    = rnd_shift(mul_p, 16);
   assign r20    = rnd_shift(mul_p, 20);
   assign r28    = rnd_shift(mul_p, 28);
   assign r32    = rnd_shift(mul_p, 32);
   assign net_r  = rnd_shift(MUL_P_W'(acc_ff), 12);
   assign seg    = sig_fetch(u_ff);
   assign wo_sum = WSUM_W'(wo_ff) + r32[WSUM_W-1:0];
   assign wh_sum = WSUM_W'(wh_ff[ctrl.sel]) + r28[WSUM_W-1:0];

   // weights and clip flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_INPUTS; j++) begin
            wh_ff[j] <= '0;
         end
         wo_ff  <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (ctrl.wr_hidden) begin
            wh_ff[ctrl.sel] <= wr_value;
         end
         if (ctrl.wr_out) begin
            wo_ff <= wr_value;
         end
         case (ctrl.op)
            L_LOAD: sat_ff <= 1'b0;
            L_WOUPD: begin
               wo_ff  <= wsat(wo_sum);
               sat_ff <= sat_ff | wclip(wo_sum);
            end
            L_WHUPD: begin
               wh_ff[ctrl.sel] <= wsat(wh_sum);
               sat_ff          <= sat_ff | wclip(wh_sum);
            end
            default: sat_ff <= sat_ff;
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (ctrl.op)
         L_LOAD:   acc_ff  <= '0;
         L_MAC:    acc_ff  <= acc_ff + mul_p[ACC_W-1:0];
         L_NET:    u_ff    <= sig_arg(net_r[ACC_W-1:0]);
         L_LOOK: begin
            t0_ff   <= seg.t0;
            diff_ff <= seg.diff;
            frac_ff <= seg.frac;
         end
         L_INTERP: h_ff    <= 16'({2'b0, t0_ff} + r20[17:0]);
         L_OMUL:   term_ff <= mul_p[ACC_W-1:0];
         L_DERIV:  dh_ff   <= r16[14:0];
         L_BACK:   g_ff    <= r16[25:0];
         L_HDELTA: dhid_ff <= r16[23:0];
         L_LRO:    lrd_ff  <= mul_p[MUL_A_W-1:0];
         L_LRH:    lrd_ff  <= mul_p[MUL_A_W-1:0];
         default:  acc_ff  <= acc_ff;
      endcase
   end

   assign hidden   = h_ff;
   assign out_term = term_ff;
   assign sat      = sat_ff;

endmodule

### rtl/core/mot_merge.sv
// ----------------------------------------------------------------------------
// mot_merge: output neuron
// sums the lane terms, output sigmoid, derivative and output delta
// ----------------------------------------------------------------------------
module mot_merge (
   input  logic                              clock,
   input  mot_pkg::merge_op_type             op,
   input  mot_pkg::term_array_type           terms,
   input  logic [15:0]                       target_value,
   output logic [15:0]                       prediction,
   output logic signed [mot_pkg::DOUT_W-1:0] d_out
);
   import mot_pkg::*;

   logic [20:0]               u_ff;
   logic [15:0]               t0_ff;
   logic signed [16:0]        diff_ff;
   logic [19:0]               frac_ff;
   logic [15:0]               pred_ff;
   logic [14:0]               dp_ff;
   logic signed [DOUT_W-1:0]  dout_ff;

   logic signed [ACC_W-1:0]   net_sum;
   logic signed [MUL_P_W-1:0] net_r, r16, r20;
   logic signed [17:0]        mul_a;
   logic signed [20:0]        mul_b;
   logic signed [38:0]        mul_p;
   logic signed [16:0]        err;
   sig_seg_type               seg;

   always_comb begin
      net_sum = '0;
      for (int i = 0; i < NUM_HIDDEN; i++) begin
         net_sum = net_sum + terms[i];
      end
   end

   assign err = signed'({1'b0, target_value}) - signed'({1'b0, pred_ff});

   always_comb begin
      case (op)
         M_INTERP: begin
            mul_a = 18'(diff_ff);
            mul_b = {1'b0, frac_ff};
         end
         M_DERIV: begin
            mul_a = {2'b0, pred_ff};
            mul_b = {4'b0, 17'h10000 - {1'b0, pred_ff}};
         end
         M_DOUT: begin
            mul_a = 18'(err);
            mul_b = {6'b0, dp_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 39'(mul_a) * 39'(mul_b);
   assign net_r = rnd_shift(MUL_P_W'(net_sum), 16);
   assign r16   = rnd_shift(MUL_P_W'(mul_p), 16);
   assign r20   = rnd_shift(MUL_P_W'(mul_p), 20);
   assign seg   = sig_fetch(u_ff);

   always_ff @(posedge clock) begin
      case (op)
         M_NET: u_ff <= sig_arg(net_r[ACC_W-1:0]);
         M_LOOK: begin
            t0_ff   <= seg.t0;
            diff_ff <= seg.diff;
            frac_ff <= seg.frac;
         end
         M_INTERP: pred_ff <= 16'({2'b0, t0_ff} + r20[17:0]);
         M_DERIV:  dp_ff   <= r16[14:0];
         M_DOUT:   dout_ff <= r16[DOUT_W-1:0];
         default:  u_ff    <= u_ff;
      endcase
   end

   assign prediction = pred_ff;
   assign d_out      = dout_ff;

endmodule

### rtl/core/mlp_online_backprop_trainer.sv
// ----------------------------------------------------------------------------
// mlp_online_backprop_trainer: 3-2-1 sigmoid network with online sgd training
// two hidden-neuron lanes, an output merge stage and a step sequencer
// ----------------------------------------------------------------------------
// sequencing: infer runs hidden mac, net, look, interp, then output mul, net, look,
// interp and done; train adds deriv, dout, back, hdelta and the weight updates; a write
// goes straight to done; one transaction at a time, as the per-lane multiplier is reused
// for every step of the dependent chain; a new request is taken while the previous result still waits on rsp
// reset: synchronous, active high; clears weights to zero, learn_rate to 6554
module mlp_online_backprop_trainer (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: feature_a[15:0] feature_b[31:16] feature_c[47:32]
   //            target_value[63:48] weight_index[66:64] weight_value[90:67]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mot_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: cmd[1:0]
   input  logic [1:0]                         req_tuser,
   // rsp_tdata: prediction[15:0] hidden_first[31:16] hidden_second[47:32]
   //            saturated[48]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mot_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [15:0]                        csr_wr_data
);
   import mot_pkg::*;

   state_type                state_ff, state_in;
   logic [SEL_W-1:0]         sel_ff, sel_in;
   cmd_type                  cmd_ff;
   feat_array_type           x_ff;
   logic [15:0]              target_ff;
   logic [15:0]              learn_rate_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   // request fields
   cmd_type                  req_cmd;
   logic [2:0]               req_widx;
   logic signed [23:0]       req_wval;
   logic                     req_take;

   // sequencer outputs
   lane_op_type              lane_op;
   merge_op_type             merge_op;
   logic [SEL_W-1:0]         lane_sel;
   logic                     load_rsp;
   logic                     sel_last;
   lane_ctrl_type            lane_ctrl [NUM_HIDDEN];

   // lane and merge results
   logic [15:0]              hid [NUM_HIDDEN];
   term_array_type           terms;
   logic [NUM_HIDDEN-1:0]    lane_sat;
   logic [15:0]              pred;
   logic signed [DOUT_W-1:0] d_out;
   logic [15:0]              hid_second;

   assign req_cmd  = cmd_type'(req_tuser);
   assign req_widx = req_tdata[66:64];
   assign req_wval = req_tdata[90:67];
   assign req_take = req_tvalid && req_tready;
   assign sel_last = (sel_ff == SEL_W'(NUM_INPUTS - 1));

   // learning rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         learn_rate_ff <= 16'd6554;
      end else if (csr_wr_en) begin
         learn_rate_ff <= csr_wr_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            sel_in = '0;
            if (req_take) begin
               state_in = (req_cmd == CMD_WRITE) ? ST_DONE : ST_HMAC;
            end
         end
         ST_HMAC: begin
            sel_in = sel_ff + 1'b1;
            if (sel_last) begin
               state_in = ST_HNET;
               sel_in   = '0;
            end
         end
         ST_HNET:    state_in = ST_HLOOK;
         ST_HLOOK:   state_in = ST_HINTERP;
         ST_HINTERP: state_in = ST_OMUL;
         ST_OMUL:    state_in = ST_ONET;
         ST_ONET:    state_in = ST_OLOOK;
         ST_OLOOK:   state_in = ST_OINTERP;
         ST_OINTERP: state_in = (cmd_ff == CMD_TRAIN) ? ST_ODERIV : ST_DONE;
         ST_ODERIV:  state_in = ST_ODOUT;
         ST_ODOUT:   state_in = ST_BACK;
         ST_BACK:    state_in = ST_HDELTA;
         ST_HDELTA:  state_in = ST_LRO;
         ST_LRO:     state_in = ST_WOUPD;
         ST_WOUPD:   state_in = ST_LRH;
         ST_LRH: begin
            state_in = ST_WHUPD;
            sel_in   = '0;
         end
         ST_WHUPD: begin
            sel_in = sel_ff + 1'b1;
            if (sel_last) begin
               state_in = ST_DONE;
               sel_in   = '0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      lane_op    = L_NOP;
      merge_op   = M_NOP;
      lane_sel   = sel_ff;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no transaction is taken while reset is held
            req_tready = !reset;
            lane_sel   = SEL_W'(req_widx[2:1]);
            if (req_take && req_cmd != CMD_WRITE) begin
               lane_op = L_LOAD;
            end
         end
         ST_HMAC:    lane_op = L_MAC;
         ST_HNET:    lane_op = L_NET;
         ST_HLOOK:   lane_op = L_LOOK;
         ST_HINTERP: lane_op = L_INTERP;
         ST_OMUL:    lane_op = L_OMUL;
         ST_ONET: begin
            lane_op  = L_DERIV;
            merge_op = M_NET;
         end
         ST_OLOOK:   merge_op = M_LOOK;
         ST_OINTERP: merge_op = M_INTERP;
         ST_ODERIV:  merge_op = M_DERIV;
         ST_ODOUT:   merge_op = M_DOUT;
         ST_BACK:    lane_op = L_BACK;
         ST_HDELTA:  lane_op = L_HDELTA;
         ST_LRO:     lane_op = L_LRO;
         ST_WOUPD:   lane_op = L_WOUPD;
         ST_LRH:     lane_op = L_LRH;
         ST_WHUPD:   lane_op = L_WHUPD;
         ST_DONE:    load_rsp = !rsp_valid_ff || rsp_tready;
         default:    lane_op = L_NOP;
      endcase
   end

   // per-lane control; weight index 0-5 is input*2+neuron, 6-7 output weight
   always_comb begin
      for (int n = 0; n < NUM_HIDDEN; n++) begin
         lane_ctrl[n].op        = lane_op;
         lane_ctrl[n].sel       = lane_sel;
         lane_ctrl[n].wr_hidden = req_take && (req_cmd == CMD_WRITE)
                                  && (req_widx < 3'd6) && (req_widx[0] == n[0])
                                  && (req_widx[2:1] < 2'(NUM_INPUTS));
         lane_ctrl[n].wr_out    = req_take && (req_cmd == CMD_WRITE)
                                  && (req_widx >= 3'd6) && (req_widx[0] == n[0]);
      end
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   // request transaction capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_cmd;
         x_ff[0]   <= req_tdata[15:0];
         if (NUM_INPUTS > 1) begin
            x_ff[NUM_INPUTS > 1 ? 1 : 0] <= req_tdata[31:16];
         end
         if (NUM_INPUTS > 2) begin
            x_ff[NUM_INPUTS - 1] <= req_tdata[47:32];
         end
         target_ff <= req_tdata[63:48];
      end
   end

   // hidden neuron lanes
   for (genvar n = 0; n < NUM_HIDDEN; n++) begin : g_lane
      mot_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl[n]),
         .features   (x_ff),
         .learn_rate (learn_rate_ff),
         .d_out      (d_out),
         .wr_value   (req_wval),
         .hidden     (hid[n]),
         .out_term   (terms[n]),
         .sat        (lane_sat[n])
      );
   end

   // output neuron
   mot_merge u_merge (
      .clock        (clock),
      .op           (merge_op),
      .terms        (terms),
      .target_value (target_ff),
      .prediction   (pred),
      .d_out        (d_out)
   );

   // absent second neuron reads zero
   if (NUM_HIDDEN > 1) begin : g_h2
      assign hid_second = hid[NUM_HIDDEN - 1];
   end else begin : g_h1
      assign hid_second = 16'd0;
   end

   // response register, frees the core while the result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         if (cmd_ff == CMD_WRITE) begin
            rsp_data_ff <= '0;
         end else begin
            rsp_data_ff <= {7'd0, (cmd_ff == CMD_TRAIN) && (|lane_sat),
                            hid_second, hid[0], pred};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a weight write skips the network and answers at once
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_cmd == CMD_WRITE) |=> (state_ff == ST_DONE))
      else $error("weight write did not go straight to done");

   // a new response only comes out of the done step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside done");

   // input index stays inside the feature vector
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HMAC || state_ff == ST_WHUPD) |-> (sel_ff <= SEL_W'(NUM_INPUTS - 1)))
      else $error("feature index out of range");

   // inference never reports a clipped update
   assert property (@(posedge clock) disable iff (reset)
      (load_rsp && cmd_ff != CMD_TRAIN) |=> !rsp_tdata[48])
      else $error("saturated set without a train step");
`endif

endmodule
